@@ rtl/core/bldc_comm_pkg.sv @@
// ----------------------------------------------------------------------------
// bldc_comm_pkg
// Shared types, codes and lookup functions of the six-step commutator.
// ----------------------------------------------------------------------------
`default_nettype none

package bldc_comm_pkg;

  // transaction kinds on the input channel (tuser)
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  // register indexes on the configuration port
  localparam logic REG_RUN_DUTY   = 1'b0;
  localparam logic REG_BRAKE_STEP = 1'b1;

  localparam logic [15:0] RUN_DUTY_RESET   = 16'h0800;
  localparam logic [15:0] BRAKE_STEP_RESET = 16'd40;

  // frame characters
  localparam logic [7:0] CHAR_HDR   = 8'h6D; // 'm'
  localparam logic [7:0] CHAR_DASH  = 8'h2D; // '-'
  localparam logic [7:0] CHAR_RIGHT = 8'h52; // 'R'
  localparam logic [7:0] CHAR_LEFT  = 8'h4C; // 'L'
  localparam logic [7:0] CHAR_BRAKE = 8'h42; // 'B'
  localparam logic [7:0] CHAR_STOP  = 8'h53; // 'S'

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_CCW   = 3'd1,
    MODE_CW    = 3'd2,
    MODE_BRAKE = 3'd3,
    MODE_STOP  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REPLY_NONE  = 3'd0,
    REPLY_R_OK  = 3'd1,
    REPLY_L_OK  = 3'd2,
    REPLY_B_OK  = 3'd3,
    REPLY_STOP  = 3'd4
  } reply_t;

  typedef enum logic [1:0] {
    PH_HDR  = 2'd0,
    PH_DASH = 2'd1,
    PH_CMD  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] run_duty;
    logic [15:0] brake_step;
  } cfg_t;

  typedef struct packed {
    logic       opcode;
    logic [2:0] hall_code;
    logic [7:0] command_byte;
  } item_t;

  typedef struct packed {
    logic [5:0]  gate_enable;
    logic [15:0] duty;
    logic [2:0]  step_number;
    mode_t       run_mode;
    reply_t      reply;
  } result_t;

  // hall code to step, zero for the two invalid codes
  function automatic logic [2:0] hall_to_step(input logic [2:0] hall);
    logic [2:0] s;
    case (hall)
      3'b101:  s = 3'd1;
      3'b100:  s = 3'd2;
      3'b110:  s = 3'd3;
      3'b010:  s = 3'd4;
      3'b011:  s = 3'd5;
      3'b001:  s = 3'd6;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

  // gate pattern {1H,1L,2H,2L,3H,3L}; cw takes the pattern three steps on
  function automatic logic [5:0] pattern_for(input logic [2:0] step, input logic cw);
    logic [5:0] p;
    case (step)
      3'd2:    p = cw ? 6'h12 : 6'h21;
      3'd3:    p = cw ? 6'h06 : 6'h09;
      3'd4:    p = cw ? 6'h24 : 6'h18;
      3'd5:    p = cw ? 6'h21 : 6'h12;
      3'd6:    p = cw ? 6'h09 : 6'h06;
      default: p = cw ? 6'h18 : 6'h24;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/bldc_comm_apb.sv @@
// ----------------------------------------------------------------------------
// bldc_comm_apb
// Configuration registers behind a simple bus port: run duty and brake step.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_comm_apb (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  output bldc_comm_pkg::cfg_t       cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.run_duty   <= bldc_comm_pkg::RUN_DUTY_RESET;
      cfg.brake_step <= bldc_comm_pkg::BRAKE_STEP_RESET;
    end else if (wr_en) begin
      case (paddr[2])
        bldc_comm_pkg::REG_RUN_DUTY:   cfg.run_duty   <= pwdata[15:0];
        bldc_comm_pkg::REG_BRAKE_STEP: cfg.brake_step <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      bldc_comm_pkg::REG_RUN_DUTY:   prdata = {16'd0, cfg.run_duty};
      bldc_comm_pkg::REG_BRAKE_STEP: prdata = {16'd0, cfg.brake_step};
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/bldc_comm_ctrl.sv @@
// ----------------------------------------------------------------------------
// bldc_comm_ctrl
// Commutation state, frame parser and brake ramp; gives the state after
// each item.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_comm_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   en,
  input  wire bldc_comm_pkg::item_t   item,
  input  wire bldc_comm_pkg::cfg_t    cfg,
  output bldc_comm_pkg::result_t      res
);

  logic [2:0]            step, step_next;
  logic [5:0]            pattern, pattern_next;
  logic [15:0]           duty, duty_next;
  bldc_comm_pkg::mode_t  mode, mode_next;
  bldc_comm_pkg::phase_t phase, phase_next;
  bldc_comm_pkg::reply_t reply;

  logic [2:0]  h;
  logic [2:0]  adj;
  logic        cw;
  logic [15:0] braked;

  always_ff @(posedge clk) begin
    if (rst) begin
      step    <= 3'd1;
      pattern <= 6'd0;
      duty    <= 16'd0;
      mode    <= bldc_comm_pkg::MODE_IDLE;
      phase   <= bldc_comm_pkg::PH_HDR;
    end else if (en) begin
      step    <= step_next;
      pattern <= pattern_next;
      duty    <= duty_next;
      mode    <= mode_next;
      phase   <= phase_next;
    end
  end

  always_comb begin
    h      = bldc_comm_pkg::hall_to_step(item.hall_code);
    cw     = (mode == bldc_comm_pkg::MODE_CW);
    // neighbour step in the running direction, wrapping within 1..6
    if (cw) adj = (step == 3'd1) ? 3'd6 : step - 3'd1;
    else    adj = (step == 3'd6) ? 3'd1 : step + 3'd1;
    braked = (duty > cfg.brake_step) ? duty - cfg.brake_step : 16'd0;

    step_next    = step;
    pattern_next = pattern;
    duty_next    = duty;
    mode_next    = mode;
    phase_next   = phase;
    reply        = bldc_comm_pkg::REPLY_NONE;

    if (item.opcode == bldc_comm_pkg::OP_TICK) begin
      case (mode)
        bldc_comm_pkg::MODE_CCW, bldc_comm_pkg::MODE_CW: begin
          if (h != 3'd0 && h == adj) begin
            step_next    = adj;
            pattern_next = bldc_comm_pkg::pattern_for(adj, cw);
          end else if (h != 3'd0 && h == step) begin
            pattern_next = bldc_comm_pkg::pattern_for(step, cw);
          end
        end
        bldc_comm_pkg::MODE_BRAKE: begin
          duty_next = braked;
          if (braked == 16'd0) begin
            mode_next = bldc_comm_pkg::MODE_IDLE;
            reply     = bldc_comm_pkg::REPLY_STOP;
          end
        end
        default: ;
      endcase
    end else begin
      case (phase)
        bldc_comm_pkg::PH_HDR:
          phase_next = (item.command_byte == bldc_comm_pkg::CHAR_HDR) ?
                       bldc_comm_pkg::PH_DASH : bldc_comm_pkg::PH_HDR;
        bldc_comm_pkg::PH_DASH:
          phase_next = (item.command_byte == bldc_comm_pkg::CHAR_DASH) ?
                       bldc_comm_pkg::PH_CMD : bldc_comm_pkg::PH_HDR;
        bldc_comm_pkg::PH_CMD: begin
          phase_next = bldc_comm_pkg::PH_HDR;
          case (item.command_byte)
            bldc_comm_pkg::CHAR_RIGHT, bldc_comm_pkg::CHAR_LEFT: begin
              if (item.command_byte == bldc_comm_pkg::CHAR_RIGHT) begin
                mode_next = bldc_comm_pkg::MODE_CW;
                reply     = bldc_comm_pkg::REPLY_R_OK;
              end else begin
                mode_next = bldc_comm_pkg::MODE_CCW;
                reply     = bldc_comm_pkg::REPLY_L_OK;
              end
              duty_next = cfg.run_duty;
              // an invalid hall code leaves the step alone
              if (h != 3'd0) step_next = h;
            end
            bldc_comm_pkg::CHAR_BRAKE: begin
              mode_next = bldc_comm_pkg::MODE_BRAKE;
              reply     = bldc_comm_pkg::REPLY_B_OK;
            end
            bldc_comm_pkg::CHAR_STOP: begin
              mode_next = bldc_comm_pkg::MODE_STOP;
              duty_next = 16'd0;
              reply     = bldc_comm_pkg::REPLY_STOP;
            end
            default: ;
          endcase
        end
        default: phase_next = bldc_comm_pkg::PH_HDR;
      endcase
    end

    res.gate_enable = pattern_next;
    res.duty        = duty_next;
    res.step_number = step_next;
    res.run_mode    = mode_next;
    res.reply       = reply;
  end

endmodule

`default_nettype wire

@@ rtl/core/bldc_hall_six_step_commutator_core.sv @@
// ----------------------------------------------------------------------------
// bldc_hall_six_step_commutator_core
// Six-step commutator driven by hall codes, control ticks and command frames.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: tuser selects a control tick or a received command byte,
//   tdata carries the hall code and the command byte. Each input transaction
//   gives exactly one output transaction with the gate enables, duty, step,
//   mode and reply as they stand after that item.
//   Configuration: run_duty at address 0, brake_step at address 4, written
//   through the bus port while no items are in flight.
// Timing:
//   An item is captured in the input register, its result computed
//   combinationally from the commutation state and held in the result
//   register, so the result passes both registers before it is valid. One item
//   per clock is sustained while the receiver keeps tready high, set by the single state update per cycle.
// Reset and stalls:
//   rst clears both pipeline registers, the state goes to step 1, idle mode,
//   zero duty and pattern, and the registers return to their defaults. When
//   the receiver holds tready low the result waits and the input register
//   still takes one more item; after that s_tready falls until room appears.
// ----------------------------------------------------------------------------
`default_nettype none

module bldc_hall_six_step_commutator_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // hall_code[2:0], command_byte[10:3], zero fill
  input  wire logic [0:0]  s_tuser,   // opcode[0]
  // master stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,   // gate_enable[5:0], duty[21:6], step_number[24:22],
                                      // run_mode[27:25], reply[30:28], zero fill
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  bldc_comm_pkg::cfg_t    cfg;
  bldc_comm_pkg::item_t   in_item;
  bldc_comm_pkg::result_t res, out_res;
  logic                   in_vld;
  logic                   advance;

  bldc_comm_apb u_apb (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // result register has room when empty or being drained this cycle
  assign advance  = in_vld & (~m_tvalid | m_tready);
  assign s_tready = ~in_vld | advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tready) begin
      in_vld <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.opcode       <= s_tuser[0];
      in_item.hall_code    <= s_tdata[2:0];
      in_item.command_byte <= s_tdata[10:3];
    end
  end

  bldc_comm_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .en   (advance),
    .item (in_item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_res <= res;
  end

  assign m_tdata = {1'b0, out_res.reply, out_res.run_mode, out_res.step_number,
                    out_res.duty, out_res.gate_enable};

  // step number shown is always a real step
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (out_res.step_number != 3'd0 && out_res.step_number != 3'd7))
    else $error("step number out of range");

  // input side only stalls behind a full, stalled result register
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_vld && m_tvalid && !m_tready))
    else $error("input stalled without output back-pressure");

  // a stop reply leaves the motor idle or stopped with zero duty
  a_stop_reply: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.reply == bldc_comm_pkg::REPLY_STOP) |->
    (out_res.duty == 16'd0 && (out_res.run_mode == bldc_comm_pkg::MODE_IDLE ||
                              out_res.run_mode == bldc_comm_pkg::MODE_STOP)))
    else $error("stop reply with motor still driven");

  // nothing is presented straight out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!m_tvalid && !in_vld))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire
